FILE: rtl/http_packet_classifier_assert.svh
// Assertion macros shared by the checker of the HTTP packet classifier.
`ifndef HTTP_PACKET_CLASSIFIER_ASSERT_SVH
`define HTTP_PACKET_CLASSIFIER_ASSERT_SVH

// A property checked at every rising clock edge outside reset.
`define HPC_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("HTTP packet classifier assertion failed");

// A condition that must be followed by a consequence in the next cycle.
`define HPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    `HPC_ASSERT(label, clk, rst_n, (ante) |=> (cons))

`endif

FILE: rtl/hpc_pkg.sv
// Types, codes and helper functions of the HTTP packet classifier.
package hpc_pkg;

    localparam int MATCH_BYTES = 6;
    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [7:0] PROTO_TCP = 8'd6;
    localparam logic [3:0] MIN_WORDS = 4'd5;
    localparam logic [15:0] ETH_HEADER = 16'd14;
    localparam logic [15:0] POS_TYPE_HI = 16'd12;
    localparam logic [15:0] POS_TYPE_LO = 16'd13;
    localparam logic [15:0] POS_IHL = 16'd14;
    localparam logic [15:0] POS_LEN_HI = 16'd16;
    localparam logic [15:0] POS_LEN_LO = 16'd17;
    localparam logic [15:0] POS_PROTO = 16'd23;
    localparam logic [15:0] POS_SRC_FIRST = 16'd26;
    localparam logic [15:0] POS_SRC_LAST = 16'd29;
    localparam logic [15:0] POS_DST_FIRST = 16'd30;
    localparam logic [15:0] POS_DST_LAST = 16'd33;
    localparam logic [15:0] MIN_FOR_PROTO = 16'd24;
    localparam logic [15:0] TCP_DOFF_POS = 16'd12;

    typedef enum logic [2:0] {
        V_HTTP      = 3'd0,
        V_NOT_IPV4  = 3'd1,
        V_NOT_TCP   = 3'd2,
        V_BAD_HDR   = 3'd3,
        V_SHORT     = 3'd4,
        V_NO_PREFIX = 3'd5,
        V_TRUNCATED = 3'd6
    } t_verdict;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        t_verdict    verdict;
        logic [31:0] source_address;
        logic [31:0] dest_address;
        logic [15:0] source_port;
        logic [15:0] dest_port;
    } t_out_item;

    typedef logic [MATCH_BYTES-1:0][7:0] t_prefix;

    typedef struct packed {
        logic [15:0] offset;
        logic [15:0] ether_kind;
        logic [3:0]  ip_words;
        logic [7:0]  ip_protocol;
        logic [15:0] ip_total_length;
        logic [3:0]  tcp_words;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] tcp_src;
        logic [15:0] tcp_dst;
        t_prefix     prefix;
        logic        prefix_full;
    } t_frame_fields;

    function automatic logic prefix_match(input t_prefix p);
        logic is_http;
        logic is_get;
        logic is_post;
        logic is_put;
        logic is_delete;
        logic is_head;
        is_http = p[0] == "H" && p[1] == "T" && p[2] == "T" && p[3] == "P";
        is_get = p[0] == "G" && p[1] == "E" && p[2] == "T";
        is_post = p[0] == "P" && p[1] == "O" && p[2] == "S" && p[3] == "T";
        is_put = p[0] == "P" && p[1] == "U" && p[2] == "T";
        is_delete = p[0] == "D" && p[1] == "E" && p[2] == "L" && p[3] == "E"
            && p[4] == "T" && p[5] == "E";
        is_head = p[0] == "H" && p[1] == "E" && p[2] == "A" && p[3] == "D";
        return is_http || is_get || is_post || is_put || is_delete || is_head;
    endfunction

endpackage

FILE: rtl/hpc_capture.sv
// Per-frame header field capture and payload prefix collection.
module hpc_capture #(
    parameter int PREFIX_BYTES = 7
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_step,
    input  hpc_pkg::t_in_item      i_item,
    output hpc_pkg::t_frame_fields o_fields
);
    import hpc_pkg::*;

    localparam int CNT_W = $clog2(PREFIX_BYTES + 1);
    localparam int IDX_W = $clog2(MATCH_BYTES);
    localparam logic [CNT_W-1:0] PREFIX_MAX = CNT_W'(PREFIX_BYTES);
    localparam logic [CNT_W-1:0] MATCH_MAX = CNT_W'(MATCH_BYTES);

    t_frame_fields r_f;
    t_frame_fields n_f;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    logic [15:0] pos;
    logic [7:0]  b;
    logic [15:0] tcp_start;
    logic [15:0] pay_start;

    always_comb begin
        pos = r_f.offset;
        b = i_item.frame_byte;
        n_f = r_f;
        n_count = r_count;
        n_f.offset = (r_f.offset == 16'hFFFF) ? r_f.offset : r_f.offset + 16'd1;
        if (pos == POS_TYPE_HI) n_f.ether_kind[15:8] = b;
        if (pos == POS_TYPE_LO) n_f.ether_kind[7:0] = b;
        if (pos == POS_IHL) n_f.ip_words = b[3:0];
        if (pos == POS_LEN_HI) n_f.ip_total_length[15:8] = b;
        if (pos == POS_LEN_LO) n_f.ip_total_length[7:0] = b;
        if (pos == POS_PROTO) n_f.ip_protocol = b;
        if (pos >= POS_SRC_FIRST && pos <= POS_SRC_LAST) begin
            n_f.src_addr = {r_f.src_addr[23:0], b};
        end
        if (pos >= POS_DST_FIRST && pos <= POS_DST_LAST) begin
            n_f.dst_addr = {r_f.dst_addr[23:0], b};
        end
        tcp_start = ETH_HEADER + {10'd0, r_f.ip_words, 2'b00};
        pay_start = tcp_start + {10'd0, n_f.tcp_words, 2'b00};
        if (pos > ETH_HEADER) begin
            if (pos == tcp_start) n_f.tcp_src[15:8] = b;
            if (pos == tcp_start + 16'd1) n_f.tcp_src[7:0] = b;
            if (pos == tcp_start + 16'd2) n_f.tcp_dst[15:8] = b;
            if (pos == tcp_start + 16'd3) n_f.tcp_dst[7:0] = b;
            if (pos == tcp_start + TCP_DOFF_POS) n_f.tcp_words = b[7:4];
            if (pos > tcp_start + TCP_DOFF_POS && r_f.tcp_words >= MIN_WORDS
                    && r_count < PREFIX_MAX
                    && pos == pay_start + 16'(r_count)) begin
                if (r_count < MATCH_MAX) n_f.prefix[r_count[IDX_W-1:0]] = b;
                n_count = r_count + 1'b1;
            end
        end
        n_f.prefix_full = n_count == PREFIX_MAX;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_item.last_byte)) begin
            r_f <= '0;
            r_count <= '0;
        end else if (i_step) begin
            r_f <= n_f;
            r_count <= n_count;
        end
    end

    assign o_fields = n_f;

endmodule

FILE: rtl/hpc_judge.sv
// Verdict logic that grades a finished frame from its captured fields.
module hpc_judge #(
    parameter int PREFIX_BYTES = 7
) (
    input  hpc_pkg::t_frame_fields i_fields,
    output hpc_pkg::t_verdict      o_verdict
);
    import hpc_pkg::*;

    logic [15:0] tcp_start;
    logic [16:0] need_len;

    always_comb begin
        tcp_start = ETH_HEADER + {10'd0, i_fields.ip_words, 2'b00};
        need_len = {11'd0, i_fields.ip_words, 2'b00} + {11'd0, i_fields.tcp_words, 2'b00}
            + 17'(PREFIX_BYTES);
        if (i_fields.offset < ETH_HEADER) begin
            o_verdict = V_TRUNCATED;
        end else if (i_fields.ether_kind != ETHERTYPE_IPV4) begin
            o_verdict = V_NOT_IPV4;
        end else if (i_fields.offset < MIN_FOR_PROTO) begin
            o_verdict = V_TRUNCATED;
        end else if (i_fields.ip_protocol != PROTO_TCP) begin
            o_verdict = V_NOT_TCP;
        end else if (i_fields.ip_words < MIN_WORDS) begin
            o_verdict = V_BAD_HDR;
        end else if (i_fields.offset < tcp_start + TCP_DOFF_POS + 16'd1) begin
            o_verdict = V_TRUNCATED;
        end else if (i_fields.tcp_words < MIN_WORDS) begin
            o_verdict = V_BAD_HDR;
        end else if ({1'b0, i_fields.ip_total_length} < need_len) begin
            o_verdict = V_SHORT;
        end else if (!i_fields.prefix_full) begin
            o_verdict = V_TRUNCATED;
        end else if (prefix_match(i_fields.prefix)) begin
            o_verdict = V_HTTP;
        end else begin
            o_verdict = V_NO_PREFIX;
        end
    end

endmodule

FILE: rtl/http_packet_classifier.sv
// Top level of the HTTP packet classifier.
// The input channel carries one Ethernet frame byte per transfer, in wire order, with
// last_byte set on the final byte of a frame. The output channel carries one result
// per frame: a verdict code and the IPv4/TCP four-tuple seen in the frame.
// A byte is held in an input register, from which the header capture and the verdict
// logic act on it; a final byte loads the result register.
// The last byte of a frame passes through the input register and then the result register.
// Throughput is one byte per cycle, set by the single capture stage, while no last byte
// stalls; the block keeps accepting bytes while a result waits in the output register
// until a last byte arrives.
// A last byte stalls in the input register only while the previous result is still
// waiting to be taken; the receiver's ready then reaches the input ready directly.
// Reset is synchronous and clears all frame state and the valid flags of the input
// and result registers; input ready is low during reset and high once it is released.
module http_packet_classifier #(
    parameter int PREFIX_BYTES = 7
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  hpc_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output hpc_pkg::t_out_item o_out_item
);
    import hpc_pkg::*;

    logic          r_in_valid;
    t_in_item      r_in;
    logic          r_out_valid;
    t_out_item     r_out;
    logic          step;
    t_frame_fields fields;
    t_verdict      verdict;

    assign step = r_in_valid && (!r_in.last_byte || !r_out_valid || i_out_ready);
    assign o_in_ready = i_rst_n && (!r_in_valid || step);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_item;
        end
    end

    hpc_capture #(
        .PREFIX_BYTES(PREFIX_BYTES)
    ) u_capture (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_item  (r_in),
        .o_fields(fields)
    );

    hpc_judge #(
        .PREFIX_BYTES(PREFIX_BYTES)
    ) u_judge (
        .i_fields (fields),
        .o_verdict(verdict)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && r_in.last_byte) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && r_in.last_byte) begin
            r_out.verdict <= verdict;
            r_out.source_address <= fields.src_addr;
            r_out.dest_address <= fields.dst_addr;
            r_out.source_port <= fields.tcp_src;
            r_out.dest_port <= fields.tcp_dst;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item = r_out;

endmodule

FILE: rtl/hpc_checker.sv
// Port-level checker of the HTTP packet classifier and its bind statement.
`include "http_packet_classifier_assert.svh"

module hpc_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input hpc_pkg::t_out_item i_out_item
);
    import hpc_pkg::*;

    // A result that is not taken stays offered unchanged.
    `HPC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready,
        i_out_valid && $stable(i_out_item))

    // Input is refused only while a result waits on a stalled receiver.
    `HPC_ASSERT(a_ready_cause, i_clk, i_rst_n,
        !i_in_ready |-> (i_out_valid && !i_out_ready))

    // No result is offered right after reset.
    `HPC_ASSERT(a_reset_idle, i_clk, i_rst_n, !$past(i_rst_n) |-> !i_out_valid)

endmodule

bind http_packet_classifier hpc_checker u_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_ready (o_in_ready),
    .i_out_valid(o_out_valid),
    .i_out_ready(i_out_ready),
    .i_out_item (o_out_item)
);
